// File: hw/rtl/ncm_pkg.sv
// ----------------------------------------------------------------------------
// ncm_pkg
// Shared types and constants for the nearest color match block: transaction
// payloads, the pipeline tag and the operation codes.
// ----------------------------------------------------------------------------
package ncm_pkg;

   // Operation codes carried in the request opcode field.
   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_CLASSIFY = 1'b1;

   // Default table depth.
   localparam int MAX_COLORS_DEFAULT = 16;

   // Largest possible squared distance (3 * 255 * 255).
   localparam int MAX_DIST_SQ = 195075;

   // One reference color or one sensor sample.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } color_type;

   // Request transaction payload.
   typedef struct packed {
      logic       opcode;
      logic [3:0] entry_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   // Response transaction payload.
   typedef struct packed {
      logic        found;
      logic [3:0]  best_index;
      logic [17:0] best_distance_sq;
   } rsp_type;

   // Tag that travels alongside each table read through the distance pipeline.
   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

endpackage

// File: hw/rtl/ncm_dist.sv
// ----------------------------------------------------------------------------
// ncm_dist
// Two-stage squared Euclidean distance unit. Stage one squares the three
// component differences, stage two sums them. The tag follows the data.
// ----------------------------------------------------------------------------
module ncm_dist (
   input  logic                clock,
   input  logic                reset,
   input  ncm_pkg::tag_type    tag_i,
   input  ncm_pkg::color_type  entry_i,
   input  ncm_pkg::color_type  sample_i,
   output ncm_pkg::tag_type    tag_o,
   output logic [17:0]         dist_o
);

   logic [7:0]       diff_r;
   logic [7:0]       diff_g;
   logic [7:0]       diff_b;
   logic [15:0]      sq_r_ff;
   logic [15:0]      sq_g_ff;
   logic [15:0]      sq_b_ff;
   logic [17:0]      dist_ff;
   ncm_pkg::tag_type tag1_ff;
   ncm_pkg::tag_type tag2_ff;

   // Absolute component differences.
   always_comb begin
      diff_r = (sample_i.red > entry_i.red) ? (sample_i.red - entry_i.red)
                                            : (entry_i.red - sample_i.red);
      diff_g = (sample_i.green > entry_i.green) ? (sample_i.green - entry_i.green)
                                                : (entry_i.green - sample_i.green);
      diff_b = (sample_i.blue > entry_i.blue) ? (sample_i.blue - entry_i.blue)
                                              : (entry_i.blue - sample_i.blue);
   end

   // Stage one: square each difference.
   always_ff @(posedge clock) begin
      sq_r_ff <= diff_r * diff_r;
      sq_g_ff <= diff_g * diff_g;
      sq_b_ff <= diff_b * diff_b;
   end

   // Stage two: sum the squares.
   always_ff @(posedge clock) begin
      dist_ff <= 18'(sq_r_ff) + 18'(sq_g_ff) + 18'(sq_b_ff);
   end

   // Tag pipeline; only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
      end else begin
         tag1_ff <= tag_i;
         tag2_ff <= tag1_ff;
      end
   end

   assign tag_o  = tag2_ff;
   assign dist_o = dist_ff;

endmodule

// File: hw/rtl/nearest_color_match_top.sv
// ----------------------------------------------------------------------------
// nearest_color_match_top
// Nearest reference color by squared Euclidean RGB distance over a table
// held in a synchronous memory.
//
//   Channel   Ports                     Transaction
//   request   start, busy, req_data     accepted when start is high, busy low
//   response  rsp_valid, rsp_data       one cycle strobe, always taken
//   config    csr_we, csr_wdata         color_count written when csr_we high
//
// A load never raises busy. A classify scans n = min(color_count,
// MAX_COLORS) entries, one memory read per cycle, then passes each read
// through the two distance stages and the compare; busy falls with the
// response. A classify with a count of zero responds in the next cycle
// without raising busy. Reset clears control state only; the table holds
// no reset value. The response side cannot stall.
// ----------------------------------------------------------------------------
module nearest_color_match_top #(
   parameter int MAX_COLORS = ncm_pkg::MAX_COLORS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ncm_pkg::req_type req_data,
   output logic             rsp_valid,
   output ncm_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [4:0]       csr_wdata
);

   localparam int AW = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
   localparam int NW = $clog2(MAX_COLORS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   ncm_pkg::color_type mem [MAX_COLORS];

   logic               state_ff, state_in;
   logic [4:0]         count_ff;
   ncm_pkg::color_type sample_ff;
   logic               issue_ff, issue_in;
   logic [NW-1:0]      rd_cnt_ff, rd_cnt_in;
   logic [NW-1:0]      last_ff, last_in;
   ncm_pkg::color_type rd_data_ff;
   ncm_pkg::tag_type   rd_tag_ff;
   ncm_pkg::tag_type   cmp_tag;
   logic [17:0]        cmp_dist;
   logic [NW-1:0]      cmp_idx_ff, cmp_idx_in;
   logic               hit_ff, hit_in;
   logic [17:0]        best_dist_ff, best_dist_in;
   logic [NW-1:0]      best_idx_ff, best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ncm_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   logic               accept;
   logic               load_wr;
   logic [NW-1:0]      scan_len;
   logic               take_new;
   logic               rd_last;

   assign accept = start && (state_ff == ST_IDLE);

   // Loads beyond the table depth are dropped.
   assign load_wr = accept && (req_data.opcode == ncm_pkg::OP_LOAD) &&
                    (32'(req_data.entry_index) < 32'(MAX_COLORS));

   // A count above the table depth scans the whole table.
   assign scan_len = (32'(count_ff) > 32'(MAX_COLORS)) ? NW'(MAX_COLORS)
                                                       : NW'(count_ff);

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_we) begin
         count_ff <= csr_wdata;
      end
   end

   // Table memory: one write port for loads, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (load_wr) begin
         mem[AW'(req_data.entry_index)] <= '{red:   req_data.red,
                                             green: req_data.green,
                                             blue:  req_data.blue};
      end
   end

   always_ff @(posedge clock) begin
      if (issue_ff) begin
         rd_data_ff <= mem[rd_cnt_ff[AW-1:0]];
      end
   end

   assign rd_last = (rd_cnt_ff == last_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff <= '0;
      end else begin
         rd_tag_ff <= '{valid: issue_ff, last: rd_last};
      end
   end

   // Distance pipeline.
   ncm_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .tag_i    (rd_tag_ff),
      .entry_i  (rd_data_ff),
      .sample_i (sample_ff),
      .tag_o    (cmp_tag),
      .dist_o   (cmp_dist)
   );

   // Strict-less compare keeps the first minimum.
   assign take_new = !hit_ff || (cmp_dist < best_dist_ff);

   // Sequencer, read issue and running minimum.
   always_comb begin
      state_in     = state_ff;
      issue_in     = issue_ff;
      rd_cnt_in    = rd_cnt_ff;
      last_in      = last_ff;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.opcode == ncm_pkg::OP_CLASSIFY)) begin
               if (scan_len == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '0;
               end else begin
                  state_in   = ST_SCAN;
                  issue_in   = 1'b1;
                  rd_cnt_in  = '0;
                  last_in    = scan_len - NW'(1);
                  cmp_idx_in = '0;
                  hit_in     = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (issue_ff) begin
               rd_cnt_in = rd_cnt_ff + NW'(1);
               if (rd_last) begin
                  issue_in = 1'b0;
               end
            end
            if (cmp_tag.valid) begin
               cmp_idx_in = cmp_idx_ff + NW'(1);
               if (take_new) begin
                  hit_in       = 1'b1;
                  best_dist_in = cmp_dist;
                  best_idx_in  = cmp_idx_ff;
               end
               if (cmp_tag.last) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{found:            1'b1,
                                   best_index:       4'(best_idx_in),
                                   best_distance_sq: best_dist_in};
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
            issue_in = 1'b0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping registers.
   always_ff @(posedge clock) begin
      rd_cnt_ff    <= rd_cnt_in;
      last_ff      <= last_in;
      cmp_idx_ff   <= cmp_idx_in;
      hit_ff       <= hit_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
      if (accept) begin
         sample_ff <= '{red: req_data.red, green: req_data.green, blue: req_data.blue};
      end
   end

   assign busy      = (state_ff == ST_SCAN);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: hw/rtl/ncm_checker.sv
// ----------------------------------------------------------------------------
// ncm_checker
// Port-level checks for the nearest color match block, bound to the top level.
// ----------------------------------------------------------------------------
module ncm_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input ncm_pkg::req_type req_data,
   input logic             rsp_valid,
   input ncm_pkg::rsp_type rsp_data,
   input logic             csr_we,
   input logic [4:0]       csr_wdata
);

   // A scan only ends by delivering its response.
   a_busy_ends_with_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy fell without a response transaction");

   // A response is never shown while a scan is still running.
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response transaction while busy");

   // A load transaction produces no response.
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.opcode == ncm_pkg::OP_LOAD)) |=> !rsp_valid)
      else $error("response transaction after a load");

   // An empty result reports a zero index and distance.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |->
         (rsp_data.best_index == 4'd0) && (rsp_data.best_distance_sq == 18'd0))
      else $error("empty result with nonzero fields");

   // The distance stays within the RGB cube diagonal.
   a_dist_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.best_distance_sq) <= ncm_pkg::MAX_DIST_SQ))
      else $error("distance out of range");

endmodule

bind nearest_color_match_top ncm_checker u_checker (.*);

// File: verif/color_match_checker.sv
// ----------------------------------------------------------------------------
// color_match_checker
// Watches the request, response and config channels of the nearest color
// match block. It keeps its own copy of the color table and count, works out
// the nearest entry for every accepted classify transaction and compares
// each response field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module color_match_checker
   import ncm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       busy,
   input  req_type    req_data,
   input  logic       rsp_valid,
   input  rsp_type    rsp_data,
   input  logic       csr_we,
   input  logic [4:0] csr_wdata,
   output int         pending_matches,
   output int         mismatch_count
);

   localparam int TABLE_DEPTH    = MAX_COLORS_DEFAULT;
   localparam int START_BOUND_SQ = 1000 * 1000;

   color_type  color_table [TABLE_DEPTH];
   logic [4:0] color_count;
   rsp_type    expected_matches [$];
   int         mismatches;

   // Scan the valid entries and keep the first strictly closer one.
   function automatic rsp_type nearest_match(input color_type sample);
      rsp_type match;
      int      scan_len;
      int      best_dist;
      int      dist_sq;
      int      dr;
      int      dg;
      int      db;
      match     = '0;
      scan_len  = (int'(color_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(color_count);
      best_dist = START_BOUND_SQ;
      for (int i = 0; i < scan_len; i++) begin
         dr      = int'(sample.red)   - int'(color_table[i].red);
         dg      = int'(sample.green) - int'(color_table[i].green);
         db      = int'(sample.blue)  - int'(color_table[i].blue);
         dist_sq = dr * dr + dg * dg + db * db;
         if (dist_sq < best_dist) begin
            best_dist              = dist_sq;
            match.found            = 1'b1;
            match.best_index       = 4'(i);
            match.best_distance_sq = 18'(dist_sq);
         end
      end
      return match;
   endfunction

   initial begin
      color_count     = '0;
      mismatches      = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         color_table[i] = '0;
      end
   end

   // All channels are sampled at the rising edge, before the edge's updates.
   always @(posedge clock) begin
      rsp_type   want;
      color_type sample;
      if (reset) begin
         color_count = '0;
         expected_matches.delete();
      end else begin
         // Compare a response transaction with the oldest prediction.
         if (rsp_valid) begin
            if (expected_matches.size() == 0) begin
               $display("%0t: unexpected response: expected none actual %h",
                        $time, rsp_data);
               mismatches++;
            end else begin
               want = expected_matches.pop_front();
               if (rsp_data.found !== want.found) begin
                  $display("%0t: found mismatch: expected %0d actual %0d",
                           $time, want.found, rsp_data.found);
                  mismatches++;
               end
               if (rsp_data.best_index !== want.best_index) begin
                  $display("%0t: best_index mismatch: expected %0d actual %0d",
                           $time, want.best_index, rsp_data.best_index);
                  mismatches++;
               end
               if (rsp_data.best_distance_sq !== want.best_distance_sq) begin
                  $display("%0t: best_distance_sq mismatch: expected %0d actual %0d",
                           $time, want.best_distance_sq, rsp_data.best_distance_sq);
                  mismatches++;
               end
            end
         end

         // Apply a load or predict a classify on an accepted transaction.
         if (start && !busy) begin
            sample = '{red: req_data.red, green: req_data.green, blue: req_data.blue};
            if (req_data.opcode == OP_LOAD) begin
               color_table[req_data.entry_index] = sample;
            end else begin
               expected_matches.push_back(nearest_match(sample));
            end
         end

         // Track the color count register; a write takes effect after this edge.
         if (csr_we) begin
            color_count = csr_wdata;
         end
      end
      pending_matches <= expected_matches.size();
      mismatch_count  <= mismatches;
   end

endmodule

// File: verif/nearest_color_match_top_tb.sv
// ----------------------------------------------------------------------------
// nearest_color_match_top_tb
// Stimulus and verdict for the nearest color match block. A directed part
// covers the empty table, the count limits, exact matches, ties and the
// largest distance; random phases then mix loads and classify transactions
// under several color counts and sender idle rates. The checker beside the
// block predicts and compares every response.
// ----------------------------------------------------------------------------
module nearest_color_match_top_tb;
   import ncm_pkg::*;

   localparam int SETTLE_CYCLES    = 24;
   localparam int PHASE_COUNT      = 8;
   localparam int ITEMS_PER_PHASE  = 68;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_we;
   logic [4:0] csr_wdata;
   int         pending_matches;
   int         mismatch_count;

   // Stimulus-side copy of loaded colors, used to aim samples near entries.
   color_type  loaded_colors [MAX_COLORS_DEFAULT];

   nearest_color_match_top uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   color_match_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_data        (req_data),
      .rsp_valid       (rsp_valid),
      .rsp_data        (rsp_data),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .pending_matches (pending_matches),
      .mismatch_count  (mismatch_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic req_type make_request(input logic op, input logic [3:0] idx,
                                            input color_type color);
      req_type item;
      item.opcode      = op;
      item.entry_index = idx;
      item.red         = color.red;
      item.green       = color.green;
      item.blue        = color.blue;
      return item;
   endfunction

   function automatic color_type random_color();
      color_type color;
      color = color_type'(24'($urandom));
      return color;
   endfunction

   // Present one transaction and return at the edge that accepts it.
   // Busy only moves at rising edges, so it is sampled at the falling edge.
   task automatic send_request(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      @(negedge clock);
      while (busy) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   task automatic load_color(input logic [3:0] idx, input color_type color);
      loaded_colors[idx] = color;
      send_request(make_request(OP_LOAD, idx, color));
   endtask

   task automatic classify(input color_type sample);
      send_request(make_request(OP_CLASSIFY, 4'($urandom), sample));
   endtask

   // Hold the sender off until every predicted response has come back.
   task automatic wait_drained(input int settle);
      start <= 1'b0;
      @(negedge clock);
      while (pending_matches != 0) begin
         @(negedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_color_count(input logic [4:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // Sender idles for a random number of cycles at the given rate.
   task automatic sender_gap(input int idle_pct);
      while (int'($urandom_range(99)) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Random transaction: mostly classify, often close to a loaded entry,
   // with loads that sometimes copy another entry to create ties.
   task automatic random_item();
      color_type  color;
      color_type  nudge;
      logic [3:0] idx;
      idx = 4'($urandom_range(15));
      if ($urandom_range(99) < 30) begin
         if ($urandom_range(4) == 0) begin
            color = loaded_colors[$urandom_range(15)];
         end else begin
            color = random_color();
         end
         load_color(idx, color);
      end else begin
         if ($urandom_range(2) == 0) begin
            nudge = color_type'({6'b0, 2'($urandom), 6'b0, 2'($urandom),
                                 6'b0, 2'($urandom)});
            color = loaded_colors[idx] ^ nudge;
         end else begin
            color = random_color();
         end
         classify(color);
      end
   endtask

   // Main stimulus sequence.
   initial begin
      logic [4:0] phase_count_value;
      int         idle_pct;
      reset     = 1'b1;
      start     = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_wdata = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A count of zero reports no match, with a zero index and distance.
      write_color_count(5'd0);
      classify('{red: 8'd10, green: 8'd20, blue: 8'd30});

      // Fill every entry, with primaries, both extremes and a duplicate.
      load_color(4'd0, '{red: 8'd0,   green: 8'd0,   blue: 8'd0});
      load_color(4'd1, '{red: 8'd255, green: 8'd255, blue: 8'd255});
      load_color(4'd2, '{red: 8'd255, green: 8'd0,   blue: 8'd0});
      load_color(4'd3, '{red: 8'd0,   green: 8'd255, blue: 8'd0});
      load_color(4'd4, '{red: 8'd0,   green: 8'd0,   blue: 8'd255});
      load_color(4'd5, '{red: 8'd128, green: 8'd128, blue: 8'd128});
      load_color(4'd6, '{red: 8'd128, green: 8'd128, blue: 8'd128});
      for (int i = 7; i < MAX_COLORS_DEFAULT; i++) begin
         load_color(4'(i), random_color());
      end

      // A single black entry against white gives the largest distance.
      wait_drained(SETTLE_CYCLES);
      write_color_count(5'd1);
      classify('{red: 8'd255, green: 8'd255, blue: 8'd255});

      // Full table: exact hit, tie kept on the first entry, both corners.
      wait_drained(SETTLE_CYCLES);
      write_color_count(5'd16);
      classify('{red: 8'd128, green: 8'd128, blue: 8'd128});
      classify('{red: 8'd0,   green: 8'd0,   blue: 8'd0});
      classify('{red: 8'd255, green: 8'd255, blue: 8'd255});

      // A count above the table depth scans the whole table.
      wait_drained(SETTLE_CYCLES);
      write_color_count(5'd31);
      classify('{red: 8'd200, green: 8'd10, blue: 8'd10});

      // Random phases under different counts and idle rates.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: phase_count_value = 5'd16;
            1: phase_count_value = 5'd1;
            2: phase_count_value = 5'd31;
            3: phase_count_value = 5'd0;
            4: phase_count_value = 5'($urandom_range(2, 15));
            5: phase_count_value = 5'($urandom_range(17, 30));
            6: phase_count_value = 5'd16;
            default: phase_count_value = 5'($urandom_range(31));
         endcase
         case (phase % 3)
            0: idle_pct = 0;
            1: idle_pct = 66;
            default: idle_pct = 12;
         endcase
         wait_drained(SETTLE_CYCLES);
         write_color_count(phase_count_value);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(39) == 0) begin
               wait_drained(0);
            end
            sender_gap(idle_pct);
            random_item();
         end
      end

      wait_drained(SETTLE_CYCLES);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
